// ===== sv/iee_pkg.sv =====
package iee_pkg;

  typedef enum logic [2:0] {
    TOK_NUM   = 3'd0,
    TOK_OPEN  = 3'd1,
    TOK_CLOSE = 3'd2,
    TOK_OPER  = 3'd3,
    TOK_END   = 3'd4
  } tok_t;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_XOR   = 3'd4;
  localparam logic [2:0] OP_PAREN = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_PAREN = 2'd3;

  typedef struct packed {
    logic push_val;
    logic push_op;
    logic pop_op;
    logic reduce;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic op_empty;
    logic op_full;
    logic val_full;
    logic val_lt2;
    logic val_empty;
    logic top_paren;
    logic [2:0] top_prec;
    logic busy;
  } dp_stat_t;

  function automatic logic [2:0] prec_of(input logic [2:0] op);
    logic [2:0] p;
    case (op)
      OP_PAREN:       p = 3'd1;
      OP_ADD, OP_SUB: p = 3'd2;
      OP_MUL, OP_DIV: p = 3'd3;
      default:        p = 3'd4;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/iee_divider.sv =====
module iee_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = neg ? (~q + 1'b1) : q;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      neg  <= num[W-1];
      q    <= num[W-1] ? (~num + 1'b1) : num;
      rem  <= '0;
      d    <= den;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], q[W-1]};
        q   <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== sv/iee_datapath.sv =====
module iee_datapath #(
  parameter int OPERATOR_DEPTH = 16,
  parameter int VALUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  iee_pkg::dp_cmd_t       cmd,
  input  logic [2:0]             op_in,
  input  logic [31:0]            num_in,
  output iee_pkg::dp_stat_t      stat,
  output logic [VALUE_WIDTH-1:0] top_val
);
  import iee_pkg::*;

  localparam int OW = $clog2(OPERATOR_DEPTH);
  localparam int VW = $clog2(VALUE_DEPTH);

  logic [2:0]             ostk [OPERATOR_DEPTH];
  logic [VALUE_WIDTH-1:0] vstk [VALUE_DEPTH];
  logic [OW:0]            otop;
  logic [VW:0]            vtop;
  logic [2:0]             otop_op;
  logic [VALUE_WIDTH-1:0] va, vb;
  logic [2:0]             rop;
  logic [1:0]             rphase;
  logic [1:0]             step;
  logic [VALUE_WIDTH-1:0] res;
  logic [VALUE_WIDTH-1:0] rd;
  logic [VALUE_WIDTH-1:0] prod;
  logic                   div_start, div_busy, div_done;
  logic [VALUE_WIDTH-1:0] div_q;

  // step: 0 idle, 1 latch a, 2 latch b and start divider, 3 write back
  iee_divider #(.W(VALUE_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(va), .den(rd),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    otop_op <= ostk[OW'(otop - 1'b1)];
    rd      <= (rphase == 2'd1) ? vstk[VW'(vtop - 2'd2)] : vstk[VW'(vtop - 1'b1)];
  end

  assign top_val = rd;
  assign prod    = va * vb;

  always_comb begin
    case (rop)
      OP_ADD:  res = va + vb;
      OP_SUB:  res = va - vb;
      OP_MUL:  res = prod;
      OP_XOR:  res = va ^ vb;
      default: res = '0;
    endcase
  end

  assign div_start = (step == 2'd2) && (rop == OP_DIV) && (rd != '0) && !rd[VALUE_WIDTH-1];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      otop <= '0;
      vtop <= '0;
      step <= 2'd0;
    end else begin
      case (step)
        2'd0: begin
          if (cmd.reduce) begin
            rop  <= otop_op;
            otop <= otop - 1'b1;
            step <= 2'd1;
          end else if (cmd.push_val) begin
            vstk[VW'(vtop)] <= VALUE_WIDTH'($signed(num_in));
            vtop <= vtop + 1'b1;
          end else if (cmd.push_op) begin
            ostk[OW'(otop)] <= op_in;
            otop <= otop + 1'b1;
          end else if (cmd.pop_op) begin
            otop <= otop - 1'b1;
          end
        end
        2'd1: begin
          va   <= rd;
          step <= 2'd2;
        end
        2'd2: begin
          vb   <= rd;
          step <= 2'd3;
        end
        default: begin
          if (rop != OP_DIV) begin
            vstk[VW'(vtop - 2'd2)] <= res;
            vtop <= vtop - 1'b1;
            step <= 2'd0;
          end else if (vb == '0 || vb[VALUE_WIDTH-1]) begin
            vstk[VW'(vtop - 2'd2)] <= '0;
            vtop <= vtop - 1'b1;
            step <= 2'd0;
          end else if (div_done) begin
            vstk[VW'(vtop - 2'd2)] <= div_q;
            vtop <= vtop - 1'b1;
            step <= 2'd0;
          end
        end
      endcase
    end
  end

  // read address for a then b follows step
  assign rphase = (step == 2'd0 && cmd.reduce) ? 2'd1 : 2'd0;

  assign stat.op_empty  = (otop == '0);
  assign stat.op_full   = (otop >= (OW + 1)'(OPERATOR_DEPTH));
  assign stat.val_full  = (vtop >= (VW + 1)'(VALUE_DEPTH));
  assign stat.val_lt2   = (vtop < (VW + 1)'(2));
  assign stat.val_empty = (vtop == '0);
  assign stat.top_paren = (otop_op == OP_PAREN);
  assign stat.top_prec  = prec_of(otop_op);
  assign stat.busy      = (step != 2'd0) || div_busy;
endmodule

// ===== sv/iee_control.sv =====
module iee_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          opcode,
  input  logic [2:0]          operator_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                take_val,
  output iee_pkg::dp_cmd_t    cmd,
  output logic [2:0]          op_sel,
  input  iee_pkg::dp_stat_t   stat
);
  import iee_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SETTLE, S_DECIDE, S_WAIT, S_EMIT
  } state_t;

  state_t     state;
  logic [2:0] tok;
  logic [2:0] opc;
  logic [1:0] err;

  assign in_stall = (state != S_IDLE) || out_valid || (cmd != '0);
  assign op_sel   = opc;

  always_ff @(posedge clk) begin
    cmd      <= '0;
    take_val <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      err       <= ST_OK;
      out_valid <= 1'b0;
      status    <= ST_OK;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            tok <= opcode;
            opc <= operator_code;
            if (opcode == TOK_END) state <= S_SETTLE;
            else if (err == ST_OK) begin
              case (opcode)
                TOK_NUM: begin
                  if (stat.val_full) err <= ST_OVER;
                  else cmd.push_val <= 1'b1;
                end
                TOK_OPEN: begin
                  if (stat.op_full) err <= ST_OVER;
                  else cmd.push_op <= 1'b1;
                  opc <= OP_PAREN;
                end
                TOK_CLOSE: state <= S_SETTLE;
                TOK_OPER:  if (operator_code <= OP_XOR) state <= S_SETTLE;
                default: ;
              endcase
            end
          end
        end
        S_SETTLE: state <= S_DECIDE;
        S_WAIT: if (!stat.busy && !cmd.reduce) state <= S_SETTLE;
        S_DECIDE: begin
          state <= S_IDLE;
          case (tok)
            TOK_CLOSE: begin
              if (stat.op_empty) err <= ST_PAREN;
              else if (stat.top_paren) cmd.pop_op <= 1'b1;
              else if (stat.val_lt2) err <= ST_UNDER;
              else begin cmd.reduce <= 1'b1; state <= S_WAIT; end
            end
            TOK_OPER: begin
              if (!stat.op_empty && stat.top_prec >= prec_of(opc)) begin
                if (stat.val_lt2) err <= ST_UNDER;
                else begin cmd.reduce <= 1'b1; state <= S_WAIT; end
              end else if (stat.op_full) err <= ST_OVER;
              else cmd.push_op <= 1'b1;
            end
            default: begin
              if (err == ST_OK && !stat.op_empty) begin
                if (stat.top_paren) err <= ST_PAREN;
                else if (stat.val_lt2) err <= ST_UNDER;
                else begin cmd.reduce <= 1'b1; state <= S_WAIT; end
                if (stat.top_paren || stat.val_lt2) state <= S_DECIDE;
              end else begin
                if (err == ST_OK && stat.val_empty) status <= ST_UNDER;
                else status <= err;
                take_val <= 1'b1;
                state    <= S_EMIT;
              end
            end
          endcase
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          err       <= ST_OK;
          cmd.clear <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> (state == S_IDLE)) else $error("emit stuck");
endmodule

// ===== sv/infix_expression_evaluator_core.sv =====
// Two-stack infix evaluator. Tokens arrive one word at a time; a number or
// open parenthesis is pushed directly, an operator or close parenthesis
// first performs the reductions it needs (a reduction that divides by a
// positive value runs through the bit-serial divider). The end token
// performs the reductions that are left, then yields one word of value and
// status and holds off input until that word is taken; status
// 1 overflow, 2 missing operand, 3 unmatched parenthesis, with value 0 on error.
module infix_expression_evaluator_core #(
  parameter int OPERATOR_DEPTH = 16,
  parameter int VALUE_DEPTH    = 16,
  parameter int VALUE_WIDTH    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] operand_value,
  input  logic [2:0]         operator_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic [1:0]         status
);
  import iee_pkg::*;

  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic [2:0]             op_sel;
  logic                   take_val;
  logic [VALUE_WIDTH-1:0] top_val;
  logic [63:0]            top_ext;
  logic [31:0]            num_hold;

  iee_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .operator_code(operator_code), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .take_val(take_val),
    .cmd(cmd), .op_sel(op_sel), .stat(stat)
  );

  iee_datapath #(
    .OPERATOR_DEPTH(OPERATOR_DEPTH), .VALUE_DEPTH(VALUE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .op_in(op_sel),
    .num_in(num_hold), .stat(stat), .top_val(top_val)
  );

  assign top_ext = 64'(top_val);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) num_hold <= operand_value;
  end

  always_ff @(posedge clk) begin
    if (take_val) result_value <= (status == ST_OK) ? top_ext[31:0] : '0;
  end
endmodule

// ===== bench/infix_expression_evaluator_checker.sv =====
module infix_expression_evaluator_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] operand_value,
  input  logic [2:0]         operator_code,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] result_value,
  input  logic [1:0]         status,
  output int                 failures,
  output int                 pending
);
  import iee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPS_DEPTH  = 16;
  localparam int VALS_DEPTH = 16;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  code;
  } answer_t;

  logic [2:0]  ops [OPS_DEPTH];
  logic [31:0] vals [VALS_DEPTH];
  int          n_ops;
  int          n_vals;
  logic [1:0]  err;
  answer_t     answers [$];

  function automatic int rank(logic [2:0] op);
    if (op == OP_PAREN) return 1;
    if (op == OP_ADD || op == OP_SUB) return 2;
    if (op == OP_MUL || op == OP_DIV) return 3;
    return 4;
  endfunction

  function automatic logic [31:0] combine(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    logic [31:0] mag;
    logic [31:0] q;
    case (op)
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 0 || b[31]) return 0;
        mag = a[31] ? -a : a;
        q = mag / b;
        return a[31] ? -q : q;
      end
      default: return a ^ b;
    endcase
  endfunction

  function automatic void flag(logic [1:0] e);
    if (err == ST_OK) err = e;
  endfunction

  function automatic bit fold();
    logic [31:0] a;
    logic [31:0] b;
    if (n_vals < 2 || n_ops == 0) begin
      flag(ST_UNDER);
      return 0;
    end
    n_ops--;
    b = vals[--n_vals];
    a = vals[--n_vals];
    vals[n_vals++] = combine(ops[n_ops], a, b);
    return 1;
  endfunction

  function automatic void push_oper(logic [2:0] op);
    if (n_ops >= OPS_DEPTH) flag(ST_OVER);
    else ops[n_ops++] = op;
  endfunction

  function automatic void evaluate(logic [2:0] kind, logic [31:0] num, logic [2:0] op);
    answer_t r;
    if (kind == TOK_END) begin
      while (err == ST_OK && n_ops > 0) begin
        if (ops[n_ops-1] == OP_PAREN) begin
          flag(ST_PAREN);
          break;
        end
        if (!fold()) break;
      end
      if (err == ST_OK && n_vals == 0) flag(ST_UNDER);
      r.value = (err == ST_OK) ? vals[n_vals-1] : 32'd0;
      r.code = err;
      answers.push_back(r);
      n_ops = 0;
      n_vals = 0;
      err = ST_OK;
      return;
    end
    if (err != ST_OK) return;
    case (kind)
      TOK_NUM: begin
        if (n_vals >= VALS_DEPTH) flag(ST_OVER);
        else vals[n_vals++] = num;
      end
      TOK_OPEN: push_oper(OP_PAREN);
      TOK_CLOSE: begin
        while (n_ops > 0 && ops[n_ops-1] != OP_PAREN)
          if (!fold()) return;
        if (n_ops == 0) flag(ST_PAREN);
        else n_ops--;
      end
      TOK_OPER: begin
        if (op > OP_XOR) return;
        while (n_ops > 0 && rank(ops[n_ops-1]) >= rank(op))
          if (!fold()) return;
        push_oper(op);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    answer_t e;
    int      bad;
    bad = 0;
    if (rst) begin
      n_ops = 0;
      n_vals = 0;
      err = ST_OK;
      answers.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) evaluate(opcode, operand_value, operator_code);
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $error("unexpected word: result_value %0d status %0d", result_value, status);
          bad = bad + 1;
        end else begin
          e = answers.pop_front();
          if (result_value !== e.value) begin
            $error("result_value: expected %0d, got %0d", $signed(e.value), result_value);
            bad = bad + 1;
          end
          if (status !== e.code) begin
            $error("status: expected %0d, got %0d", e.code, status);
            bad = bad + 1;
          end
        end
      end
      failures <= failures + bad;
      pending <= answers.size();
    end
  end
endmodule

// ===== bench/infix_expression_evaluator_core_test.sv =====
module infix_expression_evaluator_core_test;
  import iee_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         opcode = TOK_END;
  logic signed [31:0] operand_value = 0;
  logic [2:0]         operator_code = OP_ADD;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  int                 failures;
  int                 pending;
  int                 cycles = 0;
  int                 send_idle = 0;
  int                 recv_stall = 0;
  bit                 hold_off = 0;

  infix_expression_evaluator_core dut (.*);

  infix_expression_evaluator_checker chk (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic send(logic [2:0] kind, logic [31:0] num = 0, logic [2:0] op = OP_ADD);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= kind;
    operand_value <= num;
    operator_code <= op;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick();
    case ($urandom_range(5))
      0: return $urandom_range(9);
      1: return -$urandom_range(9);
      2: return 32'h7fffffff;
      3: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic operand(int depth);
    if (depth < 3 && $urandom_range(3) == 0) begin
      send(TOK_OPEN);
      operand(depth + 1);
      repeat ($urandom_range(3)) begin
        send(TOK_OPER, 0, 3'($urandom_range(4)));
        operand(depth + 1);
      end
      send(TOK_CLOSE);
    end else begin
      send(TOK_NUM, pick());
    end
  endtask

  task automatic expression();
    int mode;
    mode = $urandom_range(9);
    if (mode < 7) begin
      operand(0);
      repeat ($urandom_range(5)) begin
        send(TOK_OPER, 0, 3'($urandom_range(4)));
        operand(0);
      end
    end else begin
      repeat ($urandom_range(20))
        send(3'($urandom_range(7)), $urandom, 3'($urandom_range(7)));
    end
    send(TOK_END, $urandom, 3'($urandom_range(7)));
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(TOK_NUM, 32'h7fffffff); send(TOK_OPER, 0, OP_ADD); send(TOK_NUM, 1);
    send(TOK_OPER, 0, OP_MUL); send(TOK_NUM, 3); send(TOK_OPER, 0, OP_XOR);
    send(TOK_NUM, 32'h80000000); send(TOK_END);
    send(TOK_NUM, -7); send(TOK_OPER, 0, OP_DIV); send(TOK_NUM, 2);
    send(TOK_OPER, 0, OP_SUB); send(TOK_NUM, 5); send(TOK_OPER, 0, OP_DIV);
    send(TOK_NUM, -1); send(TOK_END);
    send(TOK_CLOSE); send(TOK_END);
    send(TOK_OPEN); send(TOK_NUM, 4); send(TOK_END);
    send(TOK_OPER, 0, OP_ADD); send(TOK_END);
    send(TOK_END);
    send(TOK_NUM, 1); send(TOK_NUM, 2); send(TOK_END);
    repeat (17) send(TOK_NUM, 9);
    send(TOK_END);
    repeat (17) send(TOK_OPEN);
    send(TOK_OPER, 0, 3'd7); send(3'd6, 32'hffffffff, 3'd5); send(TOK_END);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? 60 : 0;
      recv_stall = (phase == 2) ? 60 : (phase == 3) ? 36 : 0;
      if (phase == 3) send_idle = 36;
      repeat (30) expression();
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    fork
      begin
        hold_off = 1;
        repeat (800) @(posedge clk);
        hold_off = 0;
      end
      repeat (20) expression();
    join
    drain();
    repeat (10) expression();
    drain();
    if (failures == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== infix_expression_evaluator_core.f =====
sv/iee_pkg.sv
sv/iee_divider.sv
sv/iee_datapath.sv
sv/iee_control.sv
sv/infix_expression_evaluator_core.sv
bench/infix_expression_evaluator_checker.sv
bench/infix_expression_evaluator_core_test.sv
